// ===== sv/cbtp_pkg.sv =====
// Shared types, constants and the color table of the color-bar test pattern generator.
package cbtp_pkg;

  // Width of the configuration data and of the clamped frame dimensions.
  localparam int DIM_W = 13;
  // Width of the pixel coordinates.
  localparam int COORD_W = 12;
  // Products of a coordinate or a dimension with small constants (20 * 8191 fits).
  localparam int PROD_W = 18;
  // Width of the configuration register index.
  localparam int CFG_IDX_W = 2;
  // Width of a palette index.
  localparam int IDX_W = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  // Reset values of the frame registers.
  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = DIM_W'(1024);
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = DIM_W'(768);

  // Named palette entries.
  localparam logic [IDX_W-1:0] IDX_WHITE      = IDX_W'(0);
  localparam logic [IDX_W-1:0] IDX_RED        = IDX_W'(6);
  localparam logic [IDX_W-1:0] IDX_PURPLE     = IDX_W'(7);
  localparam logic [IDX_W-1:0] IDX_BROWN      = IDX_W'(8);
  localparam logic [IDX_W-1:0] IDX_DARK_GREY  = IDX_W'(9);
  localparam logic [IDX_W-1:0] IDX_NEAR_BLACK = IDX_W'(10);
  localparam logic [IDX_W-1:0] IDX_BLACK      = IDX_W'(11);

  // Coordinate products and frame size carried out of the first stage.
  typedef struct packed {
    logic              valid;
    logic              outside;
    logic [PROD_W-1:0] x7;
    logic [PROD_W-1:0] x21;
    logic [PROD_W-1:0] x28;
    logic [PROD_W-1:0] y3;
    logic [PROD_W-1:0] y4;
    logic [DIM_W-1:0]  w;
    logic [DIM_W-1:0]  h;
  } cbtp_prod_t;

  // Classified pixel handed back to the top level for the color lookup.
  typedef struct packed {
    logic             valid;
    logic             outside;
    logic [IDX_W-1:0] idx;
  } cbtp_class_t;

  // Four bytes of one pixel in memory order.
  typedef logic [3:0][7:0] cbtp_pixel_t;

  // Fixed twelve-entry color table; byte 0 is the least significant element.
  function automatic cbtp_pixel_t cbtp_palette(input logic [IDX_W-1:0] idx);
    cbtp_pixel_t p;
    case (idx)
      4'd0:    p = {8'hff, 8'hff, 8'hff, 8'hff};
      4'd1:    p = {8'hff, 8'hff, 8'hff, 8'h00};
      4'd2:    p = {8'hff, 8'h00, 8'hff, 8'hff};
      4'd3:    p = {8'hff, 8'h00, 8'hff, 8'h00};
      4'd4:    p = {8'hff, 8'hff, 8'h00, 8'hff};
      4'd5:    p = {8'hff, 8'hff, 8'h00, 8'h00};
      4'd6:    p = {8'hff, 8'h00, 8'h00, 8'hff};
      4'd7:    p = {8'hff, 8'h5f, 8'h01, 8'hba};
      4'd8:    p = {8'hff, 8'h00, 8'h3d, 8'h8d};
      4'd9:    p = {8'hff, 8'h22, 8'h22, 8'h22};
      4'd10:   p = {8'hff, 8'h10, 8'h10, 8'h10};
      default: p = {8'hff, 8'h00, 8'h00, 8'h00};
    endcase
    return p;
  endfunction

endpackage

// ===== sv/cbtp_bands.sv =====
// Two pipeline stages that compare the coordinate products against the frame and pick the palette index.
module cbtp_bands
  import cbtp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  cbtp_prod_t  prod,
  output cbtp_class_t cls
);

  // Stage two registers: band and threshold flags.
  logic       v2_r, v2_nxt;
  logic       out2_r, out2_nxt;
  logic       top_r, top_nxt;
  logic       mid_r, mid_nxt;
  logic [5:0] seg_ge_r, seg_ge_nxt;
  logic [3:0] blk_r, blk_nxt;
  logic       ramp_r, ramp_nxt;
  logic       q16_r, q16_nxt;
  logic       q17_r, q17_nxt;

  // Stage three registers.
  cbtp_class_t cls_r, cls_nxt;

  logic [PROD_W-1:0] wp;
  logic [PROD_W-1:0] hp;
  logic [2:0]        seg;

  // Compare the scaled coordinates with constant multiples of the frame size.
  always_comb begin
    wp       = PROD_W'(prod.w);
    hp       = PROD_W'(prod.h);
    v2_nxt   = prod.valid;
    out2_nxt = prod.outside;
    top_nxt  = prod.y3 < (hp * PROD_W'(2));
    mid_nxt  = prod.y4 < (hp * PROD_W'(3));
    // Thermometer code of 7x/w: bit k-1 set when 7x >= k*w.
    for (int k = 1; k <= 6; k++) begin
      seg_ge_nxt[k-1] = prod.x7 >= (wp * PROD_W'(k));
    end
    // Bottom band block edges at 5, 10, 15 and 20 twenty-eighths of the width.
    blk_nxt[0] = prod.x28 < (wp * PROD_W'(5));
    blk_nxt[1] = prod.x28 < (wp * PROD_W'(10));
    blk_nxt[2] = prod.x28 < (wp * PROD_W'(15));
    blk_nxt[3] = prod.x28 < (wp * PROD_W'(20));
    ramp_nxt   = prod.x7 < (wp * PROD_W'(6));
    // Within the ramp 21x/w lies in 15..17, so two compares resolve it.
    q16_nxt    = prod.x21 >= (wp * PROD_W'(16));
    q17_nxt    = prod.x21 >= (wp * PROD_W'(17));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out2_r   <= out2_nxt;
      top_r    <= top_nxt;
      mid_r    <= mid_nxt;
      seg_ge_r <= seg_ge_nxt;
      blk_r    <= blk_nxt;
      ramp_r   <= ramp_nxt;
      q16_r    <= q16_nxt;
      q17_r    <= q17_nxt;
    end
  end

  // Select the palette index from the band and threshold flags.
  always_comb begin
    seg             = 3'($countones(seg_ge_r));
    cls_nxt.valid   = v2_r;
    cls_nxt.outside = out2_r;
    if (out2_r) begin
      cls_nxt.idx = IDX_BLACK;
    end else if (top_r) begin
      cls_nxt.idx = IDX_W'(seg);
    end else if (mid_r) begin
      // Reversed bars, every second one replaced by near-black.
      cls_nxt.idx = seg[0] ? IDX_NEAR_BLACK : (IDX_RED - IDX_W'(seg));
    end else if (blk_r[0]) begin
      cls_nxt.idx = IDX_BROWN;
    end else if (blk_r[1]) begin
      cls_nxt.idx = IDX_WHITE;
    end else if (blk_r[2]) begin
      cls_nxt.idx = IDX_PURPLE;
    end else if (blk_r[3]) begin
      cls_nxt.idx = IDX_NEAR_BLACK;
    end else if (ramp_r) begin
      // Grey ramp: black, near-black, then dark grey across the step.
      cls_nxt.idx = q17_r ? IDX_DARK_GREY : (q16_r ? IDX_NEAR_BLACK : IDX_BLACK);
    end else begin
      cls_nxt.idx = IDX_NEAR_BLACK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_r.valid <= 1'b0;
    end else if (en) begin
      cls_r.valid <= cls_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cls_r.outside <= cls_nxt.outside;
      cls_r.idx     <= cls_nxt.idx;
    end
  end

  assign cls = cls_r;

  // An item outside the frame always leaves this stage as black.
  a_outside_black: assert property (@(posedge clk) disable iff (!rst_n)
    cls_r.valid && cls_r.outside |-> cls_r.idx == IDX_BLACK)
    else $error("outside pixel not mapped to black");

  // Valid moves from stage two to stage three whenever the pipeline advances.
  a_valid_follow: assert property (@(posedge clk) disable iff (!rst_n)
    en && v2_r |=> cls_r.valid)
    else $error("stage valid lost while advancing");

endmodule

// ===== sv/color_bar_test_pattern.sv =====
// Top level of the color-bar test pattern generator: handshakes, frame registers, lookup.
// The pipeline has four register stages: products, band flags, palette index and output.
// Throughput: one pixel per cycle; the four stages advance together and hold on output stall.
// A stall freezes every stage, so no item is lost or repeated while out_ready is low.
// Reset (rst_n low, synchronous) clears all stage valid bits and loads width 1024, height 768.
// Configuration writes are always accepted; indexes beyond the register list are ignored.
module color_bar_test_pattern
  import cbtp_pkg::*;
#(
  parameter int MAX_DIM = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [COORD_W-1:0]   in_column,
  input  logic [COORD_W-1:0]   in_row,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [IDX_W-1:0]     out_palette_index,
  output logic [7:0]           out_byte0,
  output logic [7:0]           out_byte1,
  output logic [7:0]           out_byte2,
  output logic [7:0]           out_byte3,
  output logic                 out_outside_frame
);

  // Compare width that holds both a register value and the dimension limit.
  localparam int LIM_W = ($clog2(MAX_DIM + 1) > DIM_W) ? $clog2(MAX_DIM + 1) : DIM_W;
  localparam logic [LIM_W-1:0] MAX_DIM_L = LIM_W'(MAX_DIM);

  logic [DIM_W-1:0] width_r, height_r;
  logic [DIM_W-1:0] w_eff, h_eff;
  logic             en;

  cbtp_prod_t  prod_r, prod_nxt;
  cbtp_class_t cls;
  cbtp_pixel_t pix_r, pix_nxt;
  logic [IDX_W-1:0] idx_r;
  logic             outside_r;
  logic             out_valid_r;

  // The whole pipeline advances unless a finished result is waiting.
  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  // Frame size registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= FRAME_WIDTH_RST;
      height_r <= FRAME_HEIGHT_RST;
    end else if (cfg_valid) begin
      if (cfg_index == REG_FRAME_WIDTH) begin
        width_r <= cfg_data;
      end else if (cfg_index == REG_FRAME_HEIGHT) begin
        height_r <= cfg_data;
      end
    end
  end

  // Clamp the frame size to the supported maximum.
  assign w_eff = (LIM_W'(width_r) > MAX_DIM_L) ? DIM_W'(MAX_DIM_L) : width_r;
  assign h_eff = (LIM_W'(height_r) > MAX_DIM_L) ? DIM_W'(MAX_DIM_L) : height_r;

  // Stage one: frame check and constant multiples of the coordinates.
  always_comb begin
    prod_nxt.valid   = in_valid;
    prod_nxt.outside = (DIM_W'(in_column) >= w_eff) || (DIM_W'(in_row) >= h_eff);
    prod_nxt.x7      = PROD_W'(in_column) * PROD_W'(7);
    prod_nxt.x21     = PROD_W'(in_column) * PROD_W'(21);
    prod_nxt.x28     = PROD_W'(in_column) * PROD_W'(28);
    prod_nxt.y3      = PROD_W'(in_row) * PROD_W'(3);
    prod_nxt.y4      = PROD_W'(in_row) * PROD_W'(4);
    prod_nxt.w       = w_eff;
    prod_nxt.h       = h_eff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_r.valid <= 1'b0;
    end else if (en) begin
      prod_r.valid <= prod_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r.outside <= prod_nxt.outside;
      prod_r.x7      <= prod_nxt.x7;
      prod_r.x21     <= prod_nxt.x21;
      prod_r.x28     <= prod_nxt.x28;
      prod_r.y3      <= prod_nxt.y3;
      prod_r.y4      <= prod_nxt.y4;
      prod_r.w       <= prod_nxt.w;
      prod_r.h       <= prod_nxt.h;
    end
  end

  // Stages two and three: band classification.
  cbtp_bands u_bands (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .prod  (prod_r),
    .cls   (cls)
  );

  // Stage four: color lookup into the output register.
  assign pix_nxt = cbtp_palette(cls.idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= cls.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix_r     <= pix_nxt;
      idx_r     <= cls.idx;
      outside_r <= cls.outside;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_palette_index = idx_r;
  assign out_byte0         = pix_r[0];
  assign out_byte1         = pix_r[1];
  assign out_byte2         = pix_r[2];
  assign out_byte3         = pix_r[3];
  assign out_outside_frame = outside_r;

  // A result never carries an index beyond the color table.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> idx_r <= IDX_BLACK)
    else $error("palette index out of range");

  // Every offered pixel is opaque and an outside pixel is black.
  a_alpha_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (pix_r[3] == 8'hff) &&
      (!outside_r || (pix_r[0] == 8'h00 && pix_r[1] == 8'h00 && pix_r[2] == 8'h00)))
    else $error("output color bytes inconsistent");

  // An input transfer always enters the first stage.
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> prod_r.valid)
    else $error("accepted pixel did not enter the pipeline");

endmodule

// ===== tb/color_bar_checker.sv =====
// Checker for the color-bar test pattern generator: predicts each pixel and compares results.
`timescale 1ns / 100ps

module color_bar_checker
  import cbtp_pkg::*;
#(
  parameter int MAX_DIM = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [COORD_W-1:0]   in_column,
  input  logic [COORD_W-1:0]   in_row,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [IDX_W-1:0]     out_palette_index,
  input  logic [7:0]           out_byte0,
  input  logic [7:0]           out_byte1,
  input  logic [7:0]           out_byte2,
  input  logic [7:0]           out_byte3,
  input  logic                 out_outside_frame,
  output int unsigned          mismatch_count,
  output int unsigned          pending_count
);

  // Palette entries that the package leaves unnamed.
  localparam logic [IDX_W-1:0] IDX_CYAN    = IDX_W'(1);
  localparam logic [IDX_W-1:0] IDX_YELLOW  = IDX_W'(2);
  localparam logic [IDX_W-1:0] IDX_GREEN   = IDX_W'(3);
  localparam logic [IDX_W-1:0] IDX_MAGENTA = IDX_W'(4);
  localparam logic [IDX_W-1:0] IDX_BLUE    = IDX_W'(5);

  // Number of failures reported in full before the rest are only counted.
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [IDX_W-1:0] palette_index;
    logic [7:0]       byte0;
    logic [7:0]       byte1;
    logic [7:0]       byte2;
    logic [7:0]       byte3;
    logic             outside_frame;
  } pixel_t;

  // Our own copy of the frame registers, following every configuration transfer.
  logic [DIM_W-1:0] frame_w;
  logic [DIM_W-1:0] frame_h;

  // Predicted pixels, oldest first.
  pixel_t expected_pixels[$];
  int unsigned n_bad;

  assign mismatch_count = n_bad;

  // Color table, written as the four bytes in memory order, byte 0 leftmost.
  function automatic logic [31:0] color_bytes(input logic [IDX_W-1:0] idx);
    logic [31:0] c;
    case (idx)
      IDX_WHITE:      c = 32'hffffffff;
      IDX_CYAN:       c = 32'h00ffffff;
      IDX_YELLOW:     c = 32'hffff00ff;
      IDX_GREEN:      c = 32'h00ff00ff;
      IDX_MAGENTA:    c = 32'hff00ffff;
      IDX_BLUE:       c = 32'h0000ffff;
      IDX_RED:        c = 32'hff0000ff;
      IDX_PURPLE:     c = 32'hba015fff;
      IDX_BROWN:      c = 32'h8d3d00ff;
      IDX_DARK_GREY:  c = 32'h222222ff;
      IDX_NEAR_BLACK: c = 32'h101010ff;
      default:        c = 32'h000000ff;
    endcase
    return c;
  endfunction

  // Works out the color that the test card shows at one pixel under the current frame size.
  function automatic pixel_t predict_pixel(input logic [COORD_W-1:0] col,
                                           input logic [COORD_W-1:0] row);
    int unsigned x, y, w, h, seg, idx;
    logic        outside;
    logic [31:0] c;
    pixel_t      px;
    x = col;
    y = row;
    w = (frame_w > MAX_DIM) ? MAX_DIM : frame_w;
    h = (frame_h > MAX_DIM) ? MAX_DIM : frame_h;
    // A zero dimension puts every pixel outside, so the divisions below never see zero.
    outside = (x >= w) || (y >= h);
    if (outside) begin
      idx = IDX_BLACK;
    end else if (3 * y < 2 * h) begin
      // Spectrum bars over the top two thirds.
      idx = (7 * x) / w;
    end else if (4 * y < 3 * h) begin
      // Reversed bars, every second one near-black.
      seg = (7 * x) / w;
      idx = seg[0] ? IDX_NEAR_BLACK : 6 - seg;
    end else if (28 * x < 5 * w) begin
      idx = IDX_BROWN;
    end else if (28 * x < 10 * w) begin
      idx = IDX_WHITE;
    end else if (28 * x < 15 * w) begin
      idx = IDX_PURPLE;
    end else if (28 * x < 20 * w) begin
      idx = IDX_NEAR_BLACK;
    end else if (7 * x < 6 * w) begin
      // Three-step grey ramp counting down from black.
      idx = 26 - (21 * x) / w;
    end else begin
      idx = IDX_NEAR_BLACK;
    end
    if (idx > IDX_BLACK) begin
      idx = IDX_BLACK;
    end
    c = color_bytes(IDX_W'(idx));
    px.palette_index = IDX_W'(idx);
    px.byte0         = c[31:24];
    px.byte1         = c[23:16];
    px.byte2         = c[15:8];
    px.byte3         = c[7:0];
    px.outside_frame = outside;
    return px;
  endfunction

  initial begin
    n_bad         = 0;
    pending_count = 0;
    frame_w       = FRAME_WIDTH_RST;
    frame_h       = FRAME_HEIGHT_RST;
  end

  // Watch all three channels at each rising edge.
  always @(posedge clk) begin
    pixel_t got;
    pixel_t want;
    if (!rst_n) begin
      frame_w = FRAME_WIDTH_RST;
      frame_h = FRAME_HEIGHT_RST;
      expected_pixels.delete();
    end else begin
      // Register writes; other indexes leave the frame size alone.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  frame_w = cfg_data;
          REG_FRAME_HEIGHT: frame_h = cfg_data;
          default: ;
        endcase
      end

      // Each accepted coordinate produces exactly one pixel.
      if (in_valid && in_ready) begin
        expected_pixels.push_back(predict_pixel(in_column, in_row));
      end

      // Compare each result transfer with the oldest prediction.
      if (out_valid && out_ready) begin
        got.palette_index = out_palette_index;
        got.byte0         = out_byte0;
        got.byte1         = out_byte1;
        got.byte2         = out_byte2;
        got.byte3         = out_byte3;
        got.outside_frame = out_outside_frame;
        if (expected_pixels.size() == 0) begin
          n_bad = n_bad + 1;
          if (n_bad <= REPORT_LIMIT) begin
            $display("Unexpected pixel: idx=%0d bytes=%h %h %h %h outside=%0b",
                     got.palette_index, got.byte0, got.byte1, got.byte2, got.byte3,
                     got.outside_frame);
          end
        end else begin
          want = expected_pixels.pop_front();
          if (got.palette_index !== want.palette_index || got.byte0 !== want.byte0 ||
              got.byte1 !== want.byte1 || got.byte2 !== want.byte2 ||
              got.byte3 !== want.byte3 || got.outside_frame !== want.outside_frame) begin
            n_bad = n_bad + 1;
            if (n_bad <= REPORT_LIMIT) begin
              $display("Pixel mismatch: expected idx=%0d bytes=%h %h %h %h outside=%0b",
                       want.palette_index, want.byte0, want.byte1, want.byte2, want.byte3,
                       want.outside_frame);
              $display("                actual   idx=%0d bytes=%h %h %h %h outside=%0b",
                       got.palette_index, got.byte0, got.byte1, got.byte2, got.byte3,
                       got.outside_frame);
            end
          end
        end
      end
    end
    pending_count <= expected_pixels.size();
  end

endmodule

// ===== tb/tb_color_bar_test_pattern.sv =====
// Testbench top for the color-bar test pattern generator: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_color_bar_test_pattern;
  import cbtp_pkg::*;

  localparam int MAX_DIM = 4096;
  // Register indexes outside the list; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);
  // Cycles to let pass after the last result, well over the four-stage latency.
  localparam int DRAIN_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int N_SEGMENTS = 11;
  localparam int ITEMS_PER_SEGMENT = 110;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [COORD_W-1:0]   in_column;
  logic [COORD_W-1:0]   in_row;
  logic                 out_valid;
  logic                 out_ready;
  logic [IDX_W-1:0]     out_palette_index;
  logic [7:0]           out_byte0;
  logic [7:0]           out_byte1;
  logic [7:0]           out_byte2;
  logic [7:0]           out_byte3;
  logic                 out_outside_frame;

  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned cycle_count;
  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned cur_w;
  int unsigned cur_h;

  color_bar_test_pattern #(.MAX_DIM(MAX_DIM)) uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_column(in_column), .in_row(in_row),
    .out_valid(out_valid), .out_ready(out_ready), .out_palette_index(out_palette_index),
    .out_byte0(out_byte0), .out_byte1(out_byte1), .out_byte2(out_byte2),
    .out_byte3(out_byte3), .out_outside_frame(out_outside_frame)
  );

  color_bar_checker #(.MAX_DIM(MAX_DIM)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_column(in_column), .in_row(in_row),
    .out_valid(out_valid), .out_ready(out_ready), .out_palette_index(out_palette_index),
    .out_byte0(out_byte0), .out_byte1(out_byte1), .out_byte2(out_byte2),
    .out_byte3(out_byte3), .out_outside_frame(out_outside_frame),
    .mismatch_count(mismatch_count), .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: stall at random with the current stall rate.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog against a hung handshake or a lost pixel.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int unsigned clamp_dim(input int unsigned v);
    return (v > MAX_DIM) ? MAX_DIM : v;
  endfunction

  // Picks a coordinate: mostly inside the frame, some near band edges, some anywhere.
  function automatic logic [COORD_W-1:0] pick_coord(input int unsigned lim,
                                                    input int unsigned den);
    int unsigned r;
    int          p;
    r = $urandom_range(99);
    if (lim == 0 || r < 10) begin
      return COORD_W'($urandom_range(4095));
    end
    if (r < 25) begin
      p = int'(lim * $urandom_range(den) / den) + int'($urandom_range(4)) - 2;
      if (p < 0) begin
        p = 0;
      end else if (p > 4095) begin
        p = 4095;
      end
      return COORD_W'(p);
    end
    return COORD_W'($urandom_range(lim - 1));
  endfunction

  // One coordinate transfer, preceded by a random number of idle cycles.
  task automatic send_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
    while ($urandom_range(99) < gap_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    in_column <= col;
    in_row    <= row;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every predicted pixel has come back and the pipeline has emptied.
  task automatic wait_drained();
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_idle_mode(input int mode);
    case (mode)
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 76; stall_pct = 0;  end
      2: begin gap_pct = 0;  stall_pct = 76; end
      default: begin gap_pct = 14; stall_pct = 14; end
    endcase
  endtask

  initial begin
    int unsigned seg_w[N_SEGMENTS];
    int unsigned seg_h[N_SEGMENTS];
    seg_w = '{1024, 1, 4096, 0, 640, 8191, 7, 1920, 28, 0, 0};
    seg_h = '{768, 1, 4096, 500, 0, 8191, 3, 1080, 12, 0, 0};
    seg_w[9]  = $urandom_range(1, 4096);
    seg_h[9]  = $urandom_range(1, 4096);
    seg_w[10] = $urandom_range(1, 64);
    seg_h[10] = $urandom_range(1, 64);

    cycle_count = 0;
    gap_pct     = 0;
    stall_pct   = 0;
    rst_n       = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_FRAME_WIDTH;
    cfg_data    = '0;
    in_valid    = 1'b0;
    in_column   = '0;
    in_row      = '0;
    out_ready   = 1'b0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed pixels at the reset frame of 1024 x 768: bar edges, band edges, outside.
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1023, 12'd0);
    send_pixel(12'd146, 12'd100);
    send_pixel(12'd147, 12'd100);
    send_pixel(12'd512, 12'd300);
    send_pixel(12'd0, 12'd511);
    send_pixel(12'd0, 12'd512);
    send_pixel(12'd147, 12'd520);
    send_pixel(12'd300, 12'd575);
    send_pixel(12'd1023, 12'd540);
    send_pixel(12'd0, 12'd576);
    send_pixel(12'd182, 12'd700);
    send_pixel(12'd183, 12'd700);
    send_pixel(12'd400, 12'd700);
    send_pixel(12'd600, 12'd700);
    send_pixel(12'd731, 12'd767);
    send_pixel(12'd732, 12'd767);
    send_pixel(12'd800, 12'd767);
    send_pixel(12'd870, 12'd767);
    send_pixel(12'd878, 12'd767);
    send_pixel(12'd1024, 12'd0);
    send_pixel(12'd0, 12'd768);
    send_pixel(12'd4095, 12'd4095);
    @(negedge clk);
    in_valid <= 1'b0;

    // Random pixels over a series of frame sizes, cycling through the idle patterns.
    for (int seg = 0; seg < N_SEGMENTS; seg++) begin
      wait_drained();
      if (seg > 0) begin
        cfg_write(REG_FRAME_WIDTH, DIM_W'(seg_w[seg]));
        cfg_write(REG_FRAME_HEIGHT, DIM_W'(seg_h[seg]));
      end
      // Writes to the spare indexes must leave the 1920 x 1080 frame in place.
      if (seg == 7) begin
        cfg_write(REG_SPARE_2, DIM_W'($urandom_range(8191)));
        cfg_write(REG_SPARE_3, DIM_W'($urandom_range(8191)));
      end
      cur_w = clamp_dim(seg_w[seg]);
      cur_h = clamp_dim(seg_h[seg]);
      set_idle_mode(seg % 4);
      for (int i = 0; i < ITEMS_PER_SEGMENT; i++) begin
        send_pixel(pick_coord(cur_w, 28), pick_coord(cur_h, 12));
      end
      @(negedge clk);
      in_valid <= 1'b0;
    end

    wait_drained();
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
